### design/vdm_pkg.sv
// ----------------------------------------------------------------------------
// Vector distance metrics package
// Metric and status codes, command and flag bundles, and the output clamp.
// ----------------------------------------------------------------------------
package vdm_pkg;

	localparam logic [3:0] MET_EUCLID    = 4'd0;
	localparam logic [3:0] MET_CHEBYSHEV = 4'd1;
	localparam logic [3:0] MET_MANHATTAN = 4'd3;
	localparam logic [3:0] MET_TANIMOTO  = 4'd5;
	localparam logic [3:0] MET_COSINE    = 4'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNIMPL   = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;
	localparam logic [1:0] ST_SAT      = 2'd3;

	localparam logic [1:0] SQ_RAD = 2'd0;
	localparam logic [1:0] SQ_A   = 2'd1;
	localparam logic [1:0] SQ_B   = 2'd2;

	// Start value of the step counter for each iterative operation; it counts down to zero.
	localparam logic [6:0] EUC_LAST  = 7'd46;
	localparam logic [6:0] NORM_LAST = 7'd30;
	localparam logic [6:0] DIV_LAST  = 7'd95;

	localparam logic signed [47:0] DIST_MAX     = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] DIST_MIN     = 48'sh8000_0000_0000;
	localparam logic signed [47:0] DIST_NEG_ONE = 48'shFFFF_0000_0000;
	localparam logic [50:0]        QUO_CAP      = 51'h4_0000_0000_0000;
	localparam logic signed [52:0] ONE_Q32      = 53'sh0_0001_0000_0000;

	typedef struct packed {
		logic       take;
		logic       prep;
		logic       sq_load;
		logic [1:0] sq_src;
		logic       sq_step;
		logic       keep_ra;
		logic       mul;
		logic       dv_load;
		logic       dv_step;
		logic       res_load;
		logic [3:0] metric;
	} vdm_cmd_t;

	typedef struct packed {
		logic rad_over;
		logic tden_zero;
		logic cden_zero;
	} vdm_flags_t;

	typedef struct packed {
		logic signed [47:0] dist_v;
		logic               sat;
	} vdm_clamp_t;

	function automatic vdm_clamp_t clamp_dist(input logic signed [52:0] v);
		vdm_clamp_t r;
		r.sat = !((&v[52:47]) || !(|v[52:47]));
		if (r.sat) begin
			r.dist_v = v[52] ? DIST_MIN : DIST_MAX;
		end else begin
			r.dist_v = v[47:0];
		end
		return r;
	endfunction

endpackage

### design/vector_distance_metrics.sv
// ----------------------------------------------------------------------------
// Vector distance metrics
// Streams coordinate pairs and returns one selected distance per vector.
// ----------------------------------------------------------------------------
// One coordinate pair request is taken per cycle while a vector streams in.
// After the pair marked last, the input stalls while the distance is finished:
// Chebyshev, Manhattan and unimplemented codes use no iterative unit,
// Euclidean runs the shared square root unit (one root bit per cycle, 47-bit
// root), Tanimoto runs the divider, and Cosine takes two 31-bit roots, a
// multiply, then the divider, which produces one quotient bit per cycle.
// The result sits in an output register, so the next vector may start
// streaming while it waits to be taken; a second result waits only if the
// first has not been taken yet.

module vector_distance_metrics #(
	parameter int ELEMENT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input request channel.
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic signed [ELEMENT_WIDTH-1:0] point_value,
	input  logic signed [ELEMENT_WIDTH-1:0] center_value,
	input  logic                            last_element,
	input  logic [61:0]                     sum_sq_a,
	input  logic [61:0]                     sum_sq_b,
	// Result request channel.
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [47:0]              distance,
	output logic [1:0]                      status,
	// Metric select register; the user must write it only while the block is idle (not enforced here).
	input  logic                            cfg_write,
	input  logic [3:0]                      cfg_data
);

	vdm_pkg::vdm_cmd_t   cmd;
	vdm_pkg::vdm_flags_t flags;

	// The controller owns the handshakes, the metric register and all sequencing.
	vdm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.last_element (last_element),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.flags        (flags),
		.cmd          (cmd)
	);

	// The datapath holds the accumulators and the iterative arithmetic units.
	vdm_datapath #(
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.point_value  (point_value),
		.center_value (center_value),
		.sum_sq_a     (sum_sq_a),
		.sum_sq_b     (sum_sq_b),
		.distance     (distance),
		.status       (status)
	);

endmodule

### design/vdm_ctrl.sv
// ----------------------------------------------------------------------------
// Vector distance metrics controller
// Sequences accumulation, square roots, multiply, divide and result loading.
// ----------------------------------------------------------------------------
module vdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              last_element,
	output logic              result_valid,
	input  logic              result_stall,
	input  logic              cfg_write,
	input  logic [3:0]        cfg_data,
	input  vdm_pkg::vdm_flags_t flags,
	output vdm_pkg::vdm_cmd_t   cmd
);

	localparam logic [3:0] S_RUN   = 4'd0;
	localparam logic [3:0] S_DRAIN = 4'd1;
	localparam logic [3:0] S_PREP  = 4'd2;
	localparam logic [3:0] S_SETUP = 4'd3;
	localparam logic [3:0] S_SQRT  = 4'd4;
	localparam logic [3:0] S_SQA   = 4'd5;
	localparam logic [3:0] S_SQB0  = 4'd6;
	localparam logic [3:0] S_SQB   = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_CHK   = 4'd9;
	localparam logic [3:0] S_DIV   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0] state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic [3:0] metric_q;
	logic       out_valid_q;

	assign item_stall   = (state_q != S_RUN);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		cmd.metric = metric_q;
		cmd.sq_src = vdm_pkg::SQ_RAD;
		case (state_q)
			S_RUN: begin
				cmd.take = item_valid;
				if (item_valid && last_element) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_PREP;
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_SETUP;
			end
			S_SETUP: begin
				state_d = S_FIN;
				case (metric_q)
					vdm_pkg::MET_EUCLID: begin
						if (!flags.rad_over) begin
							cmd.sq_load = 1'b1;
							cnt_d       = vdm_pkg::EUC_LAST;
							state_d     = S_SQRT;
						end
					end
					vdm_pkg::MET_TANIMOTO: begin
						if (!flags.tden_zero) begin
							cmd.dv_load = 1'b1;
							cnt_d       = vdm_pkg::DIV_LAST;
							state_d     = S_DIV;
						end
					end
					vdm_pkg::MET_COSINE: begin
						cmd.sq_load = 1'b1;
						cmd.sq_src  = vdm_pkg::SQ_A;
						cnt_d       = vdm_pkg::NORM_LAST;
						state_d     = S_SQA;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SQRT, S_SQA, S_SQB: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q - 7'd1;
				if (cnt_q == '0) begin
					state_d = (state_q == S_SQA) ? S_SQB0 :
					          (state_q == S_SQB) ? S_MUL : S_FIN;
				end
			end
			S_SQB0: begin
				cmd.keep_ra = 1'b1;
				cmd.sq_load = 1'b1;
				cmd.sq_src  = vdm_pkg::SQ_B;
				cnt_d       = vdm_pkg::NORM_LAST;
				state_d     = S_SQB;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (flags.cden_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.dv_load = 1'b1;
					cnt_d       = vdm_pkg::DIV_LAST;
					state_d     = S_DIV;
				end
			end
			S_DIV: begin
				cmd.dv_step = 1'b1;
				cnt_d       = cnt_q - 7'd1;
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !result_stall) begin
					cmd.res_load = 1'b1;
					state_d      = S_RUN;
				end
			end
			default: state_d = S_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			cnt_q       <= '0;
			metric_q    <= vdm_pkg::MET_EUCLID;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_write) begin
				metric_q <= cfg_data;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/vdm_datapath.sv
// ----------------------------------------------------------------------------
// Vector distance metrics datapath
// Accumulators, shared square root and divider units, result register.
// ----------------------------------------------------------------------------
module vdm_datapath #(
	parameter int ELEMENT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vdm_pkg::vdm_cmd_t               cmd,
	output vdm_pkg::vdm_flags_t             flags,
	input  logic signed [ELEMENT_WIDTH-1:0] point_value,
	input  logic signed [ELEMENT_WIDTH-1:0] center_value,
	input  logic [61:0]                     sum_sq_a,
	input  logic [61:0]                     sum_sq_b,
	output logic signed [47:0]              distance,
	output logic [1:0]                      status
);

	localparam int EW = ELEMENT_WIDTH;

	// Input stage.
	logic signed [2*EW-1:0] prod_w, prod_s1;
	logic signed [EW:0]     diff_w;
	logic [EW:0]            ad_w, ad_s1;
	logic                   vld_s1;
	logic [61:0]            na_s1, nb_s1;

	assign prod_w = point_value * center_value;
	assign diff_w = point_value - center_value;
	assign ad_w   = diff_w[EW] ? (EW + 1)'(-diff_w) : diff_w;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_s1 <= prod_w;
			ad_s1   <= ad_w;
			na_s1   <= sum_sq_a;
			nb_s1   <= sum_sq_b;
		end
	end

	// Saturating accumulators.
	logic signed [63:0] dot_q, prod64;
	logic [63:0]        abs_q;
	logic [EW:0]        max_q;
	logic [64:0]        dot_sum, abs_sum;

	assign prod64  = 64'(prod_s1);
	assign dot_sum = {dot_q[63], dot_q} + {prod64[63], prod64};
	assign abs_sum = {1'b0, abs_q} + 65'(ad_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			dot_q  <= '0;
			abs_q  <= '0;
			max_q  <= '0;
		end else begin
			vld_s1 <= cmd.take;
			if (cmd.res_load) begin
				dot_q <= '0;
				abs_q <= '0;
				max_q <= '0;
			end else if (vld_s1) begin
				if (dot_sum[64] != dot_sum[63]) begin
					dot_q <= dot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					dot_q <= dot_sum[63:0];
				end
				abs_q <= abs_sum[64] ? {64{1'b1}} : abs_sum[63:0];
				if (ad_s1 > max_q) begin
					max_q <= ad_s1;
				end
			end
		end
	end

	// Derived terms, registered once the last pair is in.
	logic [62:0] s_q;
	logic [63:0] dm_q;
	logic        dneg_q, dpos_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			s_q    <= {1'b0, na_s1} + {1'b0, nb_s1};
			dm_q   <= dot_q[63] ? 64'(-dot_q) : dot_q;
			dneg_q <= dot_q[63];
			dpos_q <= !dot_q[63] && (dot_q != '0);
		end
	end

	logic [65:0] s66, two_dm, rad_full;
	logic [63:0] s64, tden;
	logic        tden_neg;

	assign s66    = 66'(s_q);
	assign two_dm = {1'b0, dm_q, 1'b0};
	assign s64    = {1'b0, s_q};

	always_comb begin
		if (!dpos_q) begin
			rad_full = s66 + two_dm;
			tden     = s64 + dm_q;
			tden_neg = 1'b0;
		end else begin
			rad_full = (s66 >= two_dm) ? s66 - two_dm : two_dm - s66;
			tden_neg = (s64 < dm_q);
			tden     = tden_neg ? dm_q - s64 : s64 - dm_q;
		end
	end

	// Square root, one result bit a step.
	logic [93:0] sq_x_q;
	logic [46:0] sq_root_q;
	logic [49:0] sq_rem_q;
	logic [51:0] rem_sh;
	logic [51:0] trial;
	logic        sq_ge;

	assign rem_sh = {sq_rem_q, sq_x_q[93:92]};
	assign trial  = {3'b0, sq_root_q, 2'b01};
	assign sq_ge  = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			case (cmd.sq_src)
				vdm_pkg::SQ_A: sq_x_q <= {na_s1, 32'd0};
				vdm_pkg::SQ_B: sq_x_q <= {nb_s1, 32'd0};
				default:       sq_x_q <= {rad_full[61:0], 32'd0};
			endcase
			sq_root_q <= '0;
			sq_rem_q  <= '0;
		end else if (cmd.sq_step) begin
			sq_x_q    <= {sq_x_q[91:0], 2'b00};
			sq_root_q <= {sq_root_q[45:0], sq_ge};
			sq_rem_q  <= sq_ge ? 50'(rem_sh - trial) : rem_sh[49:0];
		end
	end

	// Cosine denominator.
	logic [30:0] ra_q;
	logic [61:0] den_q;

	always_ff @(posedge clk) begin
		if (cmd.keep_ra) begin
			ra_q <= sq_root_q[30:0];
		end
		if (cmd.mul) begin
			den_q <= ra_q * sq_root_q[30:0];
		end
	end

	// Restoring divider, one quotient bit a step, capped.
	logic [63:0] dv_n_q, dv_d_q, dv_r_q;
	logic [50:0] dv_q_q;
	logic        dv_cap_q;
	logic [64:0] dv_sh;
	logic        dv_ge;
	logic [51:0] q_next;

	assign dv_sh  = {dv_r_q, dv_n_q[63]};
	assign dv_ge  = (dv_sh >= {1'b0, dv_d_q});
	assign q_next = {dv_q_q, dv_ge};

	always_ff @(posedge clk) begin
		if (cmd.dv_load) begin
			dv_n_q   <= dm_q;
			dv_d_q   <= (cmd.metric == vdm_pkg::MET_COSINE) ? 64'(den_q) : tden;
			dv_r_q   <= '0;
			dv_q_q   <= '0;
			dv_cap_q <= 1'b0;
		end else if (cmd.dv_step) begin
			dv_n_q <= {dv_n_q[62:0], 1'b0};
			dv_r_q <= dv_ge ? 64'(dv_sh - {1'b0, dv_d_q}) : dv_sh[63:0];
			if (!dv_cap_q) begin
				dv_q_q <= q_next[50:0];
				if (q_next >= 52'(vdm_pkg::QUO_CAP)) begin
					dv_cap_q <= 1'b1;
				end
			end
		end
	end

	assign flags.rad_over  = |rad_full[65:62];
	assign flags.tden_zero = (tden == '0);
	assign flags.cden_zero = (den_q == '0);

	// Result selection.
	logic [50:0]         quo;
	logic signed [52:0]  qs, tan_v, cos_v;
	logic [63:0]         cheb64;
	vdm_pkg::vdm_clamp_t tan_c, cos_c;
	logic signed [47:0]  dist_d;
	logic [1:0]          st_d;

	assign quo    = dv_cap_q ? vdm_pkg::QUO_CAP : dv_q_q;
	assign qs     = {2'b00, quo};
	assign tan_v  = (dneg_q != tden_neg) ? -qs : qs;
	assign cos_v  = dneg_q ? vdm_pkg::ONE_Q32 + qs : vdm_pkg::ONE_Q32 - qs;
	assign tan_c  = vdm_pkg::clamp_dist(tan_v);
	assign cos_c  = vdm_pkg::clamp_dist(cos_v);
	assign cheb64 = 64'({max_q, 16'd0});

	always_comb begin
		dist_d = '0;
		st_d   = vdm_pkg::ST_OK;
		case (cmd.metric)
			vdm_pkg::MET_EUCLID: begin
				if (flags.rad_over) begin
					dist_d = vdm_pkg::DIST_MAX;
					st_d   = vdm_pkg::ST_SAT;
				end else begin
					dist_d = {1'b0, sq_root_q};
				end
			end
			vdm_pkg::MET_CHEBYSHEV: begin
				if (cheb64 > 64'h7FFF_FFFF_FFFF) begin
					dist_d = vdm_pkg::DIST_MAX;
					st_d   = vdm_pkg::ST_SAT;
				end else begin
					dist_d = cheb64[47:0];
				end
			end
			vdm_pkg::MET_MANHATTAN: begin
				if (abs_q > 64'h7FFF_FFFF) begin
					dist_d = vdm_pkg::DIST_MAX;
					st_d   = vdm_pkg::ST_SAT;
				end else begin
					dist_d = {abs_q[31:0], 16'd0};
				end
			end
			vdm_pkg::MET_TANIMOTO: begin
				if (flags.tden_zero) begin
					st_d = vdm_pkg::ST_ZERO_DIV;
				end else begin
					dist_d = tan_c.dist_v;
					st_d   = tan_c.sat ? vdm_pkg::ST_SAT : vdm_pkg::ST_OK;
				end
			end
			vdm_pkg::MET_COSINE: begin
				if (flags.cden_zero) begin
					st_d = vdm_pkg::ST_ZERO_DIV;
				end else begin
					dist_d = cos_c.dist_v;
					st_d   = cos_c.sat ? vdm_pkg::ST_SAT : vdm_pkg::ST_OK;
				end
			end
			default: begin
				dist_d = vdm_pkg::DIST_NEG_ONE;
				st_d   = vdm_pkg::ST_UNIMPL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			distance <= dist_d;
			status   <= st_d;
		end
	end

endmodule

### design/vdm_checker.sv
// ----------------------------------------------------------------------------
// Vector distance metrics checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vdm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic signed [47:0] distance,
	input logic [1:0]        status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(distance) && $stable(status))
		else $error("stalled result changed");

	a_unimpl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == vdm_pkg::ST_UNIMPL |-> distance == vdm_pkg::DIST_NEG_ONE)
		else $error("unimplemented metric without -1");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == vdm_pkg::ST_ZERO_DIV |-> distance == '0)
		else $error("zero divisor with nonzero distance");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == vdm_pkg::ST_SAT |->
		distance == vdm_pkg::DIST_MAX || distance == vdm_pkg::DIST_MIN)
		else $error("saturated status off the limits");

endmodule

bind vector_distance_metrics vdm_checker u_vdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.distance     (distance),
	.status       (status)
);
